@@ hw/rtl/mft_pkg.sv @@
// Shared types, sizes and helpers for the multiset frequency table.
`timescale 1ns / 1ps

package mft_pkg;

   // Table sizes.
   localparam int CAPACITY    = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int COUNT_WIDTH = 32;

   // Index into the tables, and a counter that can also hold CAPACITY itself.
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Request operation codes; code 3 is unused and does nothing.
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } mft_op_type;

   // Request payload.
   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] elem_value;
   } mft_req_type;

   // Result payload.
   typedef struct packed {
      logic        done_ok;
      logic [31:0] elem_count;
      logic [31:0] total_count;
      logic [6:0]  distinct_count;
      logic        is_empty;
      logic        full_reject;
   } mft_rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACT,
      ST_SHIFT,
      ST_DONE
   } mft_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic scan;
      logic act;
      logic shift;
      logic finish;
   } mft_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;
      logic stream_end;
      logic del;
      logic rsp_free;
   } mft_status_type;

   // Clamp a stored count to the 32-bit result field.
   function automatic logic [31:0] cnt_to_out(input logic [COUNT_WIDTH-1:0] c);
      logic [COUNT_WIDTH+31:0] w;
      logic [COUNT_WIDTH+31:0] lim;
      w   = {32'd0, c};
      lim = {{COUNT_WIDTH{1'b0}}, 32'hFFFF_FFFF};
      if (w > lim) begin
         return 32'hFFFF_FFFF;
      end
      return w[31:0];
   endfunction

endpackage

@@ hw/rtl/mft_ctrl.sv @@
// Controller state machine for the multiset frequency table.
`timescale 1ns / 1ps

module mft_ctrl
   import mft_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  mft_status_type status,
   output mft_cmd_type    cmd
);

   mft_state_type state_ff;
   mft_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit || status.stream_end) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            state_in = status.del ? ST_SHIFT : ST_DONE;
         end
         ST_SHIFT: begin
            if (status.stream_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_ACT: begin
            cmd.act = 1'b1;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
         end
         ST_DONE: begin
            cmd.finish = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // A result is loaded only when the output register can take it.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.rsp_free)
      else $error("result loaded while output register busy");

   // A delete pass follows only from the action step.
   a_shift_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && $past(state_ff) != ST_SHIFT) |-> $past(status.del))
      else $error("compaction started without a delete");

   // No new request is taken while one is in progress.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> req_stall)
      else $error("request accepted while busy");

endmodule

@@ hw/rtl/mft_datapath.sv @@
// Datapath of the multiset frequency table: key and count tables, scan and result.
`timescale 1ns / 1ps

module mft_datapath
   import mft_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  mft_req_type    req_data,
   input  mft_cmd_type    cmd,
   output mft_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output mft_rsp_type    rsp_data
);

   localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

   // Tables.
   logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
   logic [COUNT_WIDTH-1:0] cnt_mem [CAPACITY];

   // Captured request.
   logic [1:0]           op_ff;
   logic [KEY_WIDTH-1:0] key_ff;

   // Scan and shift stream.
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [KEY_WIDTH-1:0]   rd_key_ff;
   logic [COUNT_WIDTH-1:0] rd_cnt_ff;
   logic                   rd_en;
   logic                   step;

   // Search result.
   logic                   found_ff;
   logic [IDX_W-1:0]       pos_ff;
   logic [COUNT_WIDTH-1:0] hit_cnt_ff;

   // Table status and result fields.
   logic [CNT_W-1:0]       used_ff, used_in;
   logic [31:0]            total_ff, total_in;
   logic                   ok_ff, rej_ff, del_ff;
   logic [COUNT_WIDTH-1:0] ecnt_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   mft_rsp_type            rsp_data_ff;

   // Write port.
   logic                   wr_key_en, wr_cnt_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [KEY_WIDTH-1:0]   wr_key;
   logic [COUNT_WIDTH-1:0] wr_cnt;

   // Action decisions.
   logic                   act_ok, act_rej, act_del, act_new;
   logic [COUNT_WIDTH-1:0] act_cnt;
   logic [CNT_W-1:0]       used_after;
   logic                   hit;

   // One read per cycle while the stream has entries left.
   assign step  = cmd.scan || cmd.shift;
   assign rd_en = step && (idx_ff < used_ff);
   assign hit   = cmd.scan && rd_vld_ff && (rd_key_ff == key_ff);

   always_comb begin
      idx_in    = idx_ff;
      rd_vld_in = rd_vld_ff;
      if (cmd.start) begin
         idx_in    = '0;
         rd_vld_in = 1'b0;
      end else if (cmd.act) begin
         idx_in    = CNT_W'(pos_ff) + CNT_W'(1);
         rd_vld_in = 1'b0;
      end else if (step) begin
         rd_vld_in = rd_en;
         if (rd_en) begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
   end

   // Decide what the request does once the search is over.
   always_comb begin
      act_ok  = 1'b0;
      act_rej = 1'b0;
      act_del = 1'b0;
      act_new = 1'b0;
      act_cnt = '0;
      case (op_ff)
         OP_ADD: begin
            if (found_ff) begin
               act_ok  = 1'b1;
               act_cnt = (hit_cnt_ff != CMAX) ? hit_cnt_ff + COUNT_WIDTH'(1) : hit_cnt_ff;
            end else if (used_ff >= CNT_W'(CAPACITY)) begin
               act_rej = 1'b1;
            end else begin
               act_ok  = 1'b1;
               act_new = 1'b1;
               act_cnt = COUNT_WIDTH'(1);
            end
         end
         OP_REMOVE: begin
            if (found_ff) begin
               act_ok = 1'b1;
               if (hit_cnt_ff > COUNT_WIDTH'(1)) begin
                  act_cnt = hit_cnt_ff - COUNT_WIDTH'(1);
               end else begin
                  act_del = 1'b1;
               end
            end
         end
         OP_LOOKUP: begin
            if (found_ff) begin
               act_ok  = 1'b1;
               act_cnt = hit_cnt_ff;
            end
         end
         default: begin
            act_ok = 1'b0;
         end
      endcase
   end

   // Write port: count update or append on the action step, move down while shifting.
   always_comb begin
      wr_key_en = 1'b0;
      wr_cnt_en = 1'b0;
      wr_addr   = pos_ff;
      wr_key    = key_ff;
      wr_cnt    = act_cnt;
      if (cmd.act) begin
         if (act_new) begin
            wr_key_en = 1'b1;
            wr_cnt_en = 1'b1;
            wr_addr   = used_ff[IDX_W-1:0];
         end else if (act_ok && !act_del && (op_ff != OP_LOOKUP) && (act_cnt != hit_cnt_ff)) begin
            wr_cnt_en = 1'b1;
         end
      end else if (cmd.shift && rd_vld_ff) begin
         wr_key_en = 1'b1;
         wr_cnt_en = 1'b1;
         wr_addr   = rd_idx_ff - IDX_W'(1);
         wr_key    = rd_key_ff;
         wr_cnt    = rd_cnt_ff;
      end
   end

   // Table memories with registered reads.
   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (wr_cnt_en) begin
         cnt_mem[wr_addr] <= wr_cnt;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[idx_ff[IDX_W-1:0]];
         rd_cnt_ff <= cnt_mem[idx_ff[IDX_W-1:0]];
         rd_idx_ff <= idx_ff[IDX_W-1:0];
      end
   end

   // Running total and entry count after the action.
   always_comb begin
      total_in = total_ff;
      if (cmd.act) begin
         if (op_ff == OP_ADD && act_ok && (act_new || hit_cnt_ff != CMAX)) begin
            if (total_ff != 32'hFFFF_FFFF) begin
               total_in = total_ff + 32'd1;
            end
         end else if (op_ff == OP_REMOVE && act_ok) begin
            if (total_ff != 32'd0) begin
               total_in = total_ff - 32'd1;
            end
         end
      end
   end

   assign used_after = del_ff ? used_ff - CNT_W'(1) : used_ff;

   always_comb begin
      used_in = used_ff;
      if (cmd.act && act_new) begin
         used_in = used_ff + CNT_W'(1);
      end else if (cmd.finish) begin
         used_in = used_after;
      end
   end

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         used_ff      <= '0;
         total_ff     <= '0;
         found_ff     <= 1'b0;
         del_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.start) begin
            found_ff <= 1'b0;
            del_ff   <= 1'b0;
         end else if (hit) begin
            found_ff <= 1'b1;
         end else if (cmd.act) begin
            del_ff <= act_del;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_data.req_type;
         key_ff <= KEY_WIDTH'($unsigned(req_data.elem_value));
      end
      if (hit) begin
         pos_ff     <= rd_idx_ff;
         hit_cnt_ff <= rd_cnt_ff;
      end
      if (cmd.act) begin
         ok_ff   <= act_ok;
         rej_ff  <= act_rej;
         ecnt_ff <= act_cnt;
      end
      if (cmd.finish) begin
         rsp_data_ff.done_ok        <= ok_ff;
         rsp_data_ff.elem_count     <= cnt_to_out(ecnt_ff);
         rsp_data_ff.total_count    <= total_ff;
         rsp_data_ff.distinct_count <= 7'(used_after);
         rsp_data_ff.is_empty       <= (used_after == '0);
         rsp_data_ff.full_reject    <= rej_ff;
      end
   end

   assign status.hit        = hit;
   assign status.stream_end = (idx_ff >= used_ff) && !rd_vld_ff;
   assign status.del        = act_del;
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The entry count never passes the capacity.
   a_used_cap: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // A match always lies inside the used part of the table.
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      hit |-> (CNT_W'(rd_idx_ff) < used_ff))
      else $error("match outside used entries");

   // A compaction write never comes from the first entry.
   a_shift_src: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift && rd_vld_ff) |-> (rd_idx_ff != '0))
      else $error("shift write from entry zero");

   // A delete is only decided for a key that was found.
   a_del_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.act && act_del) |-> found_ff)
      else $error("delete without a match");

endmodule

@@ hw/rtl/multiset_frequency_table_unit.sv @@
// Top level of the multiset frequency table: controller and datapath.
//
//   Channel   Direction  Ports                       Moves
//   request   in         req_valid/req_stall/req_data  op code and key
//   result    out        rsp_valid/rsp_stall/rsp_data  status and counts
//
// A hit is found by scanning the entries in order from the first, and a miss
// reads every entry; an empty table is not read at all. A delete then moves each
// later entry down one place, and moves none when the removed entry is the last
// one. The single read port of the tables serves both the scan and these moves.
// The next request is taken in the cycle after a result is loaded. Reset clears the
// entry count and the total; the tables need no clearing. A stalled result holds
// in the output register and the next result waits until it can be loaded.
`timescale 1ns / 1ps

module multiset_frequency_table_unit
   import mft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  mft_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mft_rsp_type rsp_data
);

   mft_cmd_type    cmd;
   mft_status_type status;

   // Sequencer.
   mft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Tables and result register.
   mft_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/multiset_frequency_table_tb.sv @@
// Self-checking testbench for the multiset frequency table unit.
`timescale 1ns / 1ps

module testbench;
   import mft_pkg::*;

   // Request code that the block ignores.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Cycles with no request or result moving before the run is declared hung.
   localparam int HANG_LIMIT = 2000;
   localparam int POOL_SIZE  = 24;
   localparam int MAX_PRINTS = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mft_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mft_rsp_type rsp_data;

   // Expected bag state, updated as each request is accepted.
   logic [31:0] bag_keys [CAPACITY];
   logic [31:0] bag_counts [CAPACITY];
   int          bag_used = 0;
   logic [31:0] bag_total = '0;

   mft_rsp_type bag_status_due [$];
   logic [31:0] key_pool [POOL_SIZE];
   int          mismatch_count = 0;
   int          quiet_phase = 0;
   int          rsp_hold = 0;
   int          hang_cycles = 0;

   multiset_frequency_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Wait cycles for either side; quiet phases run with no idling at all.
   function automatic int draw_wait();
      return quiet_phase ? 0 : $urandom_range(0, 5);
   endfunction

   // Apply one request to the expected bag and return the status it produces.
   function automatic mft_rsp_type apply_to_bag(input logic [1:0] op, input logic [31:0] key);
      mft_rsp_type status;
      int          pos;
      bit          hit;
      logic [31:0] copies;
      status = '0;
      pos    = 0;
      hit    = 1'b0;
      copies = '0;
      for (int i = 0; i < bag_used; i++) begin
         if (!hit && bag_keys[i] == key) begin
            hit = 1'b1;
            pos = i;
         end
      end
      case (op)
         OP_ADD: begin
            if (hit) begin
               status.done_ok = 1'b1;
               // A count at its ceiling stays put, and so does the total.
               if (bag_counts[pos] != '1) begin
                  bag_counts[pos]++;
                  if (bag_total != '1) bag_total++;
               end
               copies = bag_counts[pos];
            end else if (bag_used >= CAPACITY) begin
               status.full_reject = 1'b1;
            end else begin
               bag_keys[bag_used]   = key;
               bag_counts[bag_used] = 32'd1;
               bag_used++;
               if (bag_total != '1) bag_total++;
               status.done_ok = 1'b1;
               copies = 32'd1;
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               status.done_ok = 1'b1;
               if (bag_total != '0) bag_total--;
               if (bag_counts[pos] > 32'd1) begin
                  bag_counts[pos]--;
                  copies = bag_counts[pos];
               end else begin
                  // Last copy gone: close the gap and keep the order.
                  for (int i = pos; i + 1 < bag_used; i++) begin
                     bag_keys[i]   = bag_keys[i + 1];
                     bag_counts[i] = bag_counts[i + 1];
                  end
                  bag_used--;
               end
            end
         end
         OP_LOOKUP: begin
            if (hit) begin
               status.done_ok = 1'b1;
               copies = bag_counts[pos];
            end
         end
         default: begin
         end
      endcase
      status.elem_count     = copies;
      status.total_count    = bag_total;
      status.distinct_count = bag_used[6:0];
      status.is_empty       = (bag_used == 0);
      return status;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTS) begin
         $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   // Send one request; valid stays high into the next request when no gap is drawn.
   task automatic send_request(input logic [1:0] op, input logic [31:0] key);
      mft_req_type item;
      int          gap;
      gap = draw_wait();
      item.req_type   = op;
      item.elem_value = key;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bag_status_due.push_back(apply_to_bag(op, key));
   endtask

   // Drop valid and hold until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bag_status_due.size() != 0) @(posedge clock);
   endtask

   // Result check and receiver stall pattern.
   always @(posedge clock) begin
      mft_rsp_type want;
      if (reset) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (bag_status_due.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_data.elem_count, '0);
            end else begin
               want = bag_status_due.pop_front();
               if (rsp_data.done_ok !== want.done_ok)
                  report_mismatch("done_ok", 32'(rsp_data.done_ok), 32'(want.done_ok));
               if (rsp_data.elem_count !== want.elem_count)
                  report_mismatch("elem_count", rsp_data.elem_count, want.elem_count);
               if (rsp_data.total_count !== want.total_count)
                  report_mismatch("total_count", rsp_data.total_count, want.total_count);
               if (rsp_data.distinct_count !== want.distinct_count)
                  report_mismatch("distinct_count", 32'(rsp_data.distinct_count),
                                  32'(want.distinct_count));
               if (rsp_data.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(rsp_data.is_empty), 32'(want.is_empty));
               if (rsp_data.full_reject !== want.full_reject)
                  report_mismatch("full_reject", 32'(rsp_data.full_reject),
                                  32'(want.full_reject));
            end
            rsp_hold = draw_wait();
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   // Hang detection: nothing accepted on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         hang_cycles = 0;
      end else begin
         hang_cycles++;
      end
      if (hang_cycles >= HANG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Requests against an empty bag, including the unused code.
   task automatic test_empty_bag();
      send_request(OP_LOOKUP, 32'h0000_0000);
      send_request(OP_REMOVE, 32'h7FFF_FFFF);
      send_request(OP_UNUSED, 32'hFFFF_FFFF);
   endtask

   // Keys at the edges of the signed range, repeated adds and lookups.
   task automatic test_key_extremes();
      send_request(OP_ADD, 32'h8000_0000);
      send_request(OP_ADD, 32'h7FFF_FFFF);
      send_request(OP_ADD, 32'h0000_0000);
      send_request(OP_ADD, 32'hFFFF_FFFF);
      send_request(OP_ADD, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h8000_0000);
      send_request(OP_LOOKUP, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h1234_5678);
      send_request(OP_UNUSED, 32'h0000_0000);
   endtask

   // Deleting an entry in the middle, then decrementing and missing keys.
   task automatic test_remove_compaction();
      send_request(OP_REMOVE, 32'h7FFF_FFFF);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'h7FFF_FFFF);
      send_request(OP_REMOVE, 32'h0000_0000);
      send_request(OP_REMOVE, 32'h7FFF_FFFF);
      send_request(OP_REMOVE, 32'h8000_0000);
      send_request(OP_REMOVE, 32'h0000_0000);
      send_request(OP_REMOVE, 32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF);
   endtask

   // Fill the table, hit the full case, pause, then empty it again.
   task automatic test_fill_and_drain();
      logic [31:0] key;
      int          pick;
      quiet_phase = 0;
      while (bag_used < CAPACITY) begin
         if (bag_used > 0 && $urandom_range(0, 3) == 0) begin
            key = bag_keys[$urandom_range(0, bag_used - 1)];
         end else begin
            key = $urandom;
         end
         send_request(OP_ADD, key);
      end
      // Table full: new keys bounce, stored keys still count up.
      for (int i = 0; i < 12; i++) begin
         pick = $urandom_range(0, 2);
         key = (pick == 0) ? $urandom : bag_keys[$urandom_range(0, CAPACITY - 1)];
         send_request((pick == 2) ? OP_LOOKUP : OP_ADD, key);
      end
      drain_results();
      quiet_phase = 1;
      send_request(OP_REMOVE, bag_keys[0]);
      send_request(OP_ADD, $urandom);
      quiet_phase = 0;
      while (bag_used > 0) begin
         key = bag_keys[$urandom_range(0, bag_used - 1)];
         send_request(($urandom_range(0, 4) == 0) ? OP_LOOKUP : OP_REMOVE, key);
      end
      send_request(OP_REMOVE, $urandom);
   endtask

   // Mixed traffic over a small key pool so that hits and deletes are common.
   task automatic test_random_mix(input int count);
      logic [31:0] key;
      logic [1:0]  op;
      int          roll;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
         key  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : $urandom;
         roll = $urandom_range(0, 99);
         if (roll < 40) op = OP_ADD;
         else if (roll < 70) op = OP_REMOVE;
         else if (roll < 95) op = OP_LOOKUP;
         else op = OP_UNUSED;
         send_request(op, key);
      end
      quiet_phase = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_bag();
      test_key_extremes();
      test_remove_compaction();
      test_fill_and_drain();
      test_random_mix(320);
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/mft_pkg.sv
hw/rtl/mft_ctrl.sv
hw/rtl/mft_datapath.sv
hw/rtl/multiset_frequency_table_unit.sv
test/multiset_frequency_table_tb.sv
